// File: rtl/wifi_frame_classifier_device_table_unit_defines.svh
// Assertion macros for the frame classifier device table.
// Each macro expects signals named clk and rst in the including scope.
`ifndef WIFI_FRAME_CLASSIFIER_DEVICE_TABLE_UNIT_DEFINES_SVH
`define WIFI_FRAME_CLASSIFIER_DEVICE_TABLE_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define WFCDT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wfcdt: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define WFCDT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wfcdt: assertion failed");

`endif

// File: rtl/wfcdt_pkg.sv
// Shared types, constants and helpers of the frame classifier device table.
// Depends on nothing; every file but the RAM and the defines header imports it.
package wfcdt_pkg;

  localparam int DEF_MAX_DEVICES = 64;
  localparam int DEF_SSID_BYTES  = 32;
  localparam int HDR_KEEP        = 34;
  localparam int NUM_STATS       = 7;

  localparam logic [12:0] TAG_START    = 13'd36;
  localparam logic [11:0] MIN_LEN      = 12'd16;
  localparam logic [11:0] EAPOL_MIN    = 12'd36;
  localparam logic [11:0] SSID_MIN_LEN = 12'd38;

  localparam logic [3:0] SUB_BEACON   = 4'h8;
  localparam logic [3:0] SUB_PROBE_RSP = 4'h5;
  localparam logic [3:0] SUB_DEAUTH   = 4'hC;
  localparam logic [3:0] SUB_DISASSOC = 4'hA;
  localparam logic [3:0] FC_QOS_DATA  = 4'h8;
  localparam logic [7:0] LLC_SNAP     = 8'hAA;
  localparam logic [7:0] LLC_CTRL     = 8'h03;
  localparam logic [7:0] ETH_EAPOL_HI = 8'h88;
  localparam logic [7:0] ETH_EAPOL_LO = 8'h8E;

  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_CTRL = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [1:0] RK_FRAME = 2'd0;
  localparam logic [1:0] RK_ENTRY = 2'd1;
  localparam logic [1:0] RK_STAT  = 2'd2;

  localparam logic [1:0] ST_EXIST = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  localparam logic [2:0] STAT_ALL    = 3'd0;
  localparam logic [2:0] STAT_MGMT   = 3'd1;
  localparam logic [2:0] STAT_DATA   = 3'd2;
  localparam logic [2:0] STAT_CTRL   = 3'd3;
  localparam logic [2:0] STAT_BEACON = 3'd4;
  localparam logic [2:0] STAT_DEAUTH = 3'd5;
  localparam logic [2:0] STAT_EAPOL  = 3'd6;
  localparam logic [5:0] STAT_DEVCNT = 6'd7;

  typedef enum logic [1:0] {
    FN_BYTE  = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_STAT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_STAT  = 2'd3
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [47:0] mac;
    logic        beacon;
    logic        deauth;
    logic        eapol;
    logic [1:0]  kind;
    logic        too_short;
    logic        ssid_upd;
    logic [5:0]  ssid_len;
    logic        copy;
    logic [7:0]  rssi;
    logic [3:0]  chan;
    logic [31:0] time_ms;
    logic [5:0]  sel;
    logic [4:0]  sp;
  } job_t;

  typedef struct packed {
    logic [7:0]  rssi;
    logic [3:0]  chan;
    logic [31:0] frames;
    logic [31:0] seen;
    logic        is_ap;
    logic [5:0]  ssid_len;
  } entry_info_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        beacon;
    logic        deauth;
    logic        eapol;
    logic [1:0]  status;
    logic [5:0]  idx;
    logic [47:0] mac;
    logic [7:0]  rssi;
    logic [3:0]  chan;
    logic [31:0] count;
    logic [31:0] seen;
    logic [8:0]  ap_ssid;
  } res_t;

  function automatic logic [7:0] ssid_char(input logic [7:0] b);
    return (b >= 8'h20 && b <= 8'h7E) ? b : 8'h2E;
  endfunction

endpackage

// File: rtl/wifi_frame_classifier_device_table_unit.sv
// Frame bytes are taken one per cycle while full is low; a frame's summary beat follows
// its last byte after a search over the table entries, an SSID copy when one is staged
// and an SSID read when ssid_pos lies within the stored SSID. Reads and statistics skip the search.
// The front end stalls while a staged SSID waits to be copied; the table engine
// handles one job at a time. Synchronous reset empties the table through the fill count and
// clears the statistics; entry memories need no clearing pass.
`include "wifi_frame_classifier_device_table_unit_defines.svh"
module wifi_frame_classifier_device_table_unit #(
  parameter int MAX_DEVICES = wfcdt_pkg::DEF_MAX_DEVICES,
  parameter int SSID_BYTES  = wfcdt_pkg::DEF_SSID_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic [1:0]         pkt_kind,
  input  logic signed [7:0]  rx_rssi,
  input  logic [3:0]         rx_channel,
  input  logic [11:0]        frame_len,
  input  logic [31:0]        time_ms,
  input  logic [5:0]         select_index,
  input  logic [4:0]         ssid_pos,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         result_kind,
  output logic               is_beacon,
  output logic               is_deauth,
  output logic               eapol_hit,
  output logic [1:0]         dev_status,
  output logic [5:0]         dev_index,
  output logic [47:0]        mac_out,
  output logic signed [7:0]  rssi_out,
  output logic [3:0]         chan_out,
  output logic [31:0]        count_out,
  output logic [31:0]        seen_out,
  output logic [8:0]         ap_ssid_byte
);
  import wfcdt_pkg::*;

  localparam int CW = $clog2(MAX_DEVICES + 1);

  job_t                       jq_din, jq_head;
  logic                       jq_push, jq_full, jq_pop, jq_empty;
  logic [SSID_BYTES-1:0][7:0] stage;
  logic                       stage_release;
  res_t                       res;
  logic [CW-1:0]              dev_count;

  wfcdt_front #(.SSID_BYTES(SSID_BYTES)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .last_byte     (last_byte),
    .pkt_kind      (pkt_kind),
    .rx_rssi       (rx_rssi),
    .rx_channel    (rx_channel),
    .frame_len     (frame_len),
    .time_ms       (time_ms),
    .select_index  (select_index),
    .ssid_pos      (ssid_pos),
    .job_push      (jq_push),
    .job           (jq_din),
    .job_full      (jq_full),
    .stage         (stage),
    .stage_release (stage_release)
  );

  wfcdt_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .empty (jq_empty),
    .head  (jq_head)
  );

  wfcdt_back #(.MAX_DEVICES(MAX_DEVICES), .SSID_BYTES(SSID_BYTES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (!jq_empty),
    .job_pop       (jq_pop),
    .job_in        (jq_head),
    .stage         (stage),
    .stage_release (stage_release),
    .empty         (empty),
    .pop           (pop),
    .res_out       (res),
    .dev_count     (dev_count)
  );

  assign result_kind  = res.kind;
  assign is_beacon    = res.beacon;
  assign is_deauth    = res.deauth;
  assign eapol_hit    = res.eapol;
  assign dev_status   = res.status;
  assign dev_index    = res.idx;
  assign mac_out      = res.mac;
  assign rssi_out     = res.rssi;
  assign chan_out     = res.chan;
  assign count_out    = res.count;
  assign seen_out     = res.seen;
  assign ap_ssid_byte = res.ap_ssid;

  `WFCDT_ASSERT_IMP(a_no_push_when_full, jq_push, !jq_full)
  `WFCDT_ASSERT_IMP(a_dev_count_bound, 1'b1, dev_count <= CW'(MAX_DEVICES))
  `WFCDT_ASSERT_IMP(a_release_while_stalled, stage_release, full)
  `WFCDT_ASSERT_NXT(a_release_unstalls, stage_release && !jq_full, !full)

endmodule

// File: rtl/wfcdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wfcdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wfcdt_front.sv
// Front end: takes frame bytes and commands, parses the header and SSID tag.
// Depends on wfcdt_pkg; pushes one job per frame or command into the job queue.
module wfcdt_front #(
  parameter int SSID_BYTES = wfcdt_pkg::DEF_SSID_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   func,
  input  logic [7:0]                   data_byte,
  input  logic                         first_byte,
  input  logic                         last_byte,
  input  logic [1:0]                   pkt_kind,
  input  logic [7:0]                   rx_rssi,
  input  logic [3:0]                   rx_channel,
  input  logic [11:0]                  frame_len,
  input  logic [31:0]                  time_ms,
  input  logic [5:0]                   select_index,
  input  logic [4:0]                   ssid_pos,
  output logic                         job_push,
  output wfcdt_pkg::job_t              job,
  input  logic                         job_full,
  output logic [SSID_BYTES-1:0][7:0]   stage,
  input  logic                         stage_release
);
  import wfcdt_pkg::*;

  typedef enum logic [3:0] {
    TAG_SEEK  = 4'b0001,
    TAG_NUM   = 4'b0010,
    TAG_FOUND = 4'b0100,
    TAG_DONE  = 4'b1000
  } tag_t;

  localparam logic [7:0] SB8 = 8'(SSID_BYTES);
  localparam logic [5:0] SB6 = 6'(SSID_BYTES);

  logic                        in_frame;
  logic                        stage_busy;
  logic [11:0]                 len_q, len_next;
  logic [1:0]                  kind_q, kind_next;
  logic [11:0]                 byte_offset, byte_offset_next;
  logic [HDR_KEEP-1:0][7:0]    hdr, hdr_next;
  logic [12:0]                 nto, nto_next;
  tag_t                        tag, tag_next;
  logic [7:0]                  tag_num, tag_num_next;
  logic [SSID_BYTES-1:0][7:0]  stage_next;
  logic [5:0]                  slen, slen_next;

  logic        accept, active;
  logic [11:0] c_pos;
  tag_t        c_tag;
  logic [5:0]  c_slen;
  logic [12:0] c_nto, nto2, tag_end, rel, len13, pos13;
  logic [7:0]  h0;
  logic        beacon, deauth, eapol_a, eapol_b, eapol, found;

  assign full = job_full || stage_busy;

  always_comb begin
    accept   = push && !full;
    active   = accept && (func == FN_BYTE) && (first_byte || in_frame);
    len_next  = first_byte ? frame_len : len_q;
    kind_next = first_byte ? pkt_kind : kind_q;
    c_pos    = first_byte ? 12'd0 : byte_offset;
    c_nto    = first_byte ? TAG_START : nto;
    c_tag    = first_byte ? TAG_SEEK : tag;
    c_slen   = first_byte ? 6'd0 : slen;
    hdr_next = first_byte ? '0 : hdr;
    stage_next   = first_byte ? '0 : stage;
    tag_num_next = first_byte ? 8'd0 : tag_num;
    nto_next  = c_nto;
    tag_next  = c_tag;
    slen_next = c_slen;
    nto2    = c_nto + 13'd2;
    tag_end = nto2 + 13'(data_byte);
    len13   = {1'b0, len_next};
    pos13   = {1'b0, c_pos};
    rel     = pos13 - nto2;
    if (c_pos < len_next) begin
      for (int i = 0; i < HDR_KEEP; i++) begin
        if (c_pos == 12'(i)) begin
          hdr_next[i] = data_byte;
        end
      end
      unique case (c_tag)
        TAG_SEEK: begin
          if (pos13 == c_nto) begin
            if (nto2 > len13) begin
              tag_next = TAG_DONE;
            end else begin
              tag_num_next = data_byte;
              tag_next     = TAG_NUM;
            end
          end
        end
        TAG_NUM: begin
          if (tag_end > len13) begin
            tag_next = TAG_DONE;
          end else if (tag_num_next == 8'd0) begin
            tag_next  = TAG_FOUND;
            slen_next = (data_byte < SB8) ? 6'(data_byte) : SB6;
          end else begin
            nto_next = tag_end;
            tag_next = TAG_SEEK;
          end
        end
        TAG_FOUND: begin
          if (pos13 >= nto2 && rel < 13'(c_slen)) begin
            for (int k = 0; k < SSID_BYTES; k++) begin
              if (rel == 13'(k)) begin
                stage_next[k] = ssid_char(data_byte);
              end
            end
          end
        end
        TAG_DONE: begin
        end
        default: begin
        end
      endcase
    end
    byte_offset_next = (c_pos != 12'hFFF) ? c_pos + 12'd1 : c_pos;

    h0      = hdr_next[0];
    beacon  = (h0[3:2] == 2'd0) && (h0[7:4] == SUB_BEACON || h0[7:4] == SUB_PROBE_RSP);
    deauth  = (h0[3:2] == 2'd0) && (h0[7:4] == SUB_DEAUTH || h0[7:4] == SUB_DISASSOC);
    eapol_a = hdr_next[24] == LLC_SNAP && hdr_next[25] == LLC_SNAP &&
              hdr_next[26] == LLC_CTRL && hdr_next[30] == ETH_EAPOL_HI &&
              hdr_next[31] == ETH_EAPOL_LO;
    eapol_b = h0[3:0] == FC_QOS_DATA && hdr_next[26] == LLC_SNAP &&
              hdr_next[27] == LLC_SNAP && hdr_next[28] == LLC_CTRL &&
              hdr_next[32] == ETH_EAPOL_HI && hdr_next[33] == ETH_EAPOL_LO;
    eapol   = kind_next == KIND_DATA && len_next >= EAPOL_MIN && (eapol_a || eapol_b);
    found   = tag_next == TAG_FOUND;

    job           = '0;
    job.mac       = {hdr_next[10], hdr_next[11], hdr_next[12],
                     hdr_next[13], hdr_next[14], hdr_next[15]};
    job.beacon    = beacon;
    job.deauth    = deauth;
    job.eapol     = eapol;
    job.kind      = kind_next;
    job.too_short = len_next < MIN_LEN;
    job.ssid_upd  = beacon && len_next >= SSID_MIN_LEN;
    job.ssid_len  = found ? slen_next : 6'd0;
    job.copy      = job.ssid_upd && found && slen_next != 6'd0;
    job.rssi      = rx_rssi;
    job.chan      = rx_channel;
    job.time_ms   = time_ms;
    job.sel       = select_index;
    job.sp        = ssid_pos;
    unique case (func_t'(func))
      FN_BYTE:  job.op = OP_FRAME;
      FN_READ:  job.op = OP_READ;
      FN_CLEAR: job.op = OP_CLEAR;
      FN_STAT:  job.op = OP_STAT;
      default:  job.op = OP_FRAME;
    endcase
    job_push = (active && last_byte) || (accept && func != FN_BYTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      stage_busy  <= 1'b0;
      len_q       <= '0;
      kind_q      <= '0;
      byte_offset <= '0;
      hdr         <= '0;
      nto         <= TAG_START;
      tag         <= TAG_SEEK;
      tag_num     <= '0;
      stage       <= '0;
      slen        <= '0;
    end else begin
      if (stage_release) begin
        stage_busy <= 1'b0;
      end
      if (active) begin
        len_q       <= len_next;
        kind_q      <= kind_next;
        byte_offset <= byte_offset_next;
        hdr         <= hdr_next;
        nto         <= nto_next;
        tag         <= tag_next;
        tag_num     <= tag_num_next;
        stage       <= stage_next;
        slen        <= slen_next;
        in_frame    <= !last_byte;
        if (last_byte && job.copy) begin
          stage_busy <= 1'b1;
        end
      end
      if (accept && func == FN_CLEAR) begin
        in_frame <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/wfcdt_jobq.sv
// Two-entry job queue between the front end and the table engine.
// Depends on wfcdt_pkg for the job type.
module wfcdt_jobq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wfcdt_pkg::job_t din,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output wfcdt_pkg::job_t head
);
  import wfcdt_pkg::*;

  job_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/wfcdt_back.sv
// Table engine: searches and updates the device table, keeps the statistics
// and holds the result register. Depends on wfcdt_pkg and wfcdt_ram.
module wfcdt_back #(
  parameter int MAX_DEVICES = wfcdt_pkg::DEF_MAX_DEVICES,
  parameter int SSID_BYTES  = wfcdt_pkg::DEF_SSID_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 job_valid,
  output logic                                 job_pop,
  input  wfcdt_pkg::job_t                      job_in,
  input  logic [SSID_BYTES-1:0][7:0]           stage,
  output logic                                 stage_release,
  output logic                                 empty,
  input  logic                                 pop,
  output wfcdt_pkg::res_t                      res_out,
  output logic [$clog2(MAX_DEVICES+1)-1:0]     dev_count
);
  import wfcdt_pkg::*;

  localparam int IW  = MAX_DEVICES > 1 ? $clog2(MAX_DEVICES) : 1;
  localparam int CW  = $clog2(MAX_DEVICES + 1);
  localparam int SD  = MAX_DEVICES * SSID_BYTES;
  localparam int SAW = SD > 1 ? $clog2(SD) : 1;
  localparam int KW  = SSID_BYTES > 1 ? $clog2(SSID_BYTES) : 1;
  localparam int INFO_W = $bits(entry_info_t);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SRCH_RD   = 9'b000000010,
    S_SRCH_CMP  = 9'b000000100,
    S_RD_GOT    = 9'b000001000,
    S_UPDATE    = 9'b000010000,
    S_COPY      = 9'b000100000,
    S_SSID_RD   = 9'b001000000,
    S_SSID_WAIT = 9'b010000000,
    S_EMIT      = 9'b100000000
  } state_t;

  state_t      state;
  job_t        job;
  logic [CW-1:0] i;
  logic [IW-1:0] idx;
  logic        is_new;
  entry_info_t old_info, new_info, info_rd;
  logic [5:0]  cur_slen;
  logic [KW-1:0] k;
  logic [31:0] stats [NUM_STATS];
  res_t        res;
  logic        out_valid;

  logic [IW-1:0]     rd_addr;
  logic [47:0]       mac_rd;
  logic [INFO_W-1:0] info_rdata;
  logic [SAW-1:0]    ssid_addr;
  logic [7:0]        ssid_rd;
  logic [31:0]       ssid_base, ssid_off;
  logic              copy_last;
  logic              sel_hit;

  assign empty   = !out_valid;
  assign info_rd = entry_info_t'(info_rdata);

  // A staged SSID is also let go when the table is full and nothing is stored.
  always_comb begin
    job_pop   = (state == S_IDLE) && job_valid;
    rd_addr   = (state == S_IDLE) ? IW'(job_in.sel) : IW'(i);
    new_info.rssi     = job.rssi;
    new_info.chan     = job.chan;
    new_info.frames   = old_info.frames + 32'd1;
    new_info.seen     = job.time_ms;
    new_info.is_ap    = old_info.is_ap | job.beacon;
    new_info.ssid_len = job.ssid_upd ? job.ssid_len : old_info.ssid_len;
    ssid_base = 32'(idx) * 32'(SSID_BYTES);
    ssid_off  = (state == S_COPY) ? 32'(k) : 32'(job.sp);
    ssid_addr = SAW'(ssid_base + ssid_off);
    copy_last = 6'(k) == job.ssid_len - 6'd1;
    stage_release = ((state == S_COPY) && copy_last) ||
                    ((state == S_SRCH_RD) && (i == dev_count) &&
                     (dev_count == CW'(MAX_DEVICES)) && job.copy);
    sel_hit   = 16'(job_in.sel) < 16'(dev_count);
  end

  wfcdt_ram #(.WIDTH(48), .DEPTH(MAX_DEVICES)) u_mac_ram (
    .clk   (clk),
    .we    (state == S_UPDATE && is_new),
    .waddr (idx),
    .wdata (job.mac),
    .raddr (rd_addr),
    .rdata (mac_rd)
  );

  wfcdt_ram #(.WIDTH(INFO_W), .DEPTH(MAX_DEVICES)) u_info_ram (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (idx),
    .wdata (INFO_W'(new_info)),
    .raddr (rd_addr),
    .rdata (info_rdata)
  );

  wfcdt_ram #(.WIDTH(8), .DEPTH(SD)) u_ssid_ram (
    .clk   (clk),
    .we    (state == S_COPY),
    .waddr (ssid_addr),
    .wdata (stage[k]),
    .raddr (ssid_addr),
    .rdata (ssid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dev_count <= '0;
      out_valid <= 1'b0;
      res       <= '0;
      for (int s = 0; s < NUM_STATS; s++) begin
        stats[s] <= '0;
      end
    end else begin
      if (state == S_EMIT && (!out_valid || pop)) begin
        res_out   <= res;
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            job <= job_in;
            unique case (job_in.op)
              OP_CLEAR: begin
                dev_count <= '0;
                for (int s = 0; s < NUM_STATS; s++) begin
                  stats[s] <= '0;
                end
              end
              OP_STAT: begin
                res.kind <= RK_STAT;
                if (job_in.sel < STAT_DEVCNT) begin
                  res.count <= stats[job_in.sel[2:0]];
                end else if (job_in.sel == STAT_DEVCNT) begin
                  res.count <= 32'(dev_count);
                end
                state <= S_EMIT;
              end
              OP_READ: begin
                res.kind <= RK_ENTRY;
                idx      <= IW'(job_in.sel);
                state    <= sel_hit ? S_RD_GOT : S_EMIT;
              end
              OP_FRAME: begin
                res.kind <= RK_FRAME;
                stats[STAT_ALL] <= stats[STAT_ALL] + 32'd1;
                if (job_in.kind == KIND_MGMT) begin
                  stats[STAT_MGMT] <= stats[STAT_MGMT] + 32'd1;
                end else if (job_in.kind == KIND_DATA) begin
                  stats[STAT_DATA] <= stats[STAT_DATA] + 32'd1;
                end else if (job_in.kind == KIND_CTRL) begin
                  stats[STAT_CTRL] <= stats[STAT_CTRL] + 32'd1;
                end
                if (job_in.too_short) begin
                  res.status <= ST_SHORT;
                  state      <= S_EMIT;
                end else begin
                  if (job_in.beacon) begin
                    stats[STAT_BEACON] <= stats[STAT_BEACON] + 32'd1;
                  end
                  if (job_in.deauth) begin
                    stats[STAT_DEAUTH] <= stats[STAT_DEAUTH] + 32'd1;
                  end
                  if (job_in.eapol) begin
                    stats[STAT_EAPOL] <= stats[STAT_EAPOL] + 32'd1;
                  end
                  res.beacon <= job_in.beacon;
                  res.deauth <= job_in.deauth;
                  res.eapol  <= job_in.eapol;
                  i          <= '0;
                  state      <= S_SRCH_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          if (i == dev_count) begin
            if (dev_count == CW'(MAX_DEVICES)) begin
              res.status <= ST_FULL;
              res.mac    <= job.mac;
              state      <= S_EMIT;
            end else begin
              is_new    <= 1'b1;
              idx       <= IW'(dev_count);
              dev_count <= dev_count + CW'(1);
              old_info  <= '0;
              state     <= S_UPDATE;
            end
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (mac_rd == job.mac) begin
            is_new   <= 1'b0;
            idx      <= IW'(i);
            old_info <= info_rd;
            state    <= S_UPDATE;
          end else begin
            i     <= i + CW'(1);
            state <= S_SRCH_RD;
          end
        end
        S_UPDATE: begin
          res.status  <= is_new ? ST_NEW : ST_EXIST;
          res.idx     <= 6'(idx);
          res.mac     <= job.mac;
          res.rssi    <= new_info.rssi;
          res.chan    <= new_info.chan;
          res.count   <= new_info.frames;
          res.seen    <= new_info.seen;
          res.ap_ssid <= {new_info.is_ap, 8'd0};
          cur_slen    <= new_info.ssid_len;
          k           <= '0;
          if (job.copy) begin
            state <= S_COPY;
          end else if (6'(job.sp) < new_info.ssid_len) begin
            state <= S_SSID_RD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_COPY: begin
          if (copy_last) begin
            state <= (6'(job.sp) < cur_slen) ? S_SSID_RD : S_EMIT;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_RD_GOT: begin
          res.idx     <= 6'(idx);
          res.mac     <= mac_rd;
          res.rssi    <= info_rd.rssi;
          res.chan    <= info_rd.chan;
          res.count   <= info_rd.frames;
          res.seen    <= info_rd.seen;
          res.ap_ssid <= {info_rd.is_ap, 8'd0};
          state       <= (6'(job.sp) < info_rd.ssid_len) ? S_SSID_RD : S_EMIT;
        end
        S_SSID_RD: begin
          state <= S_SSID_WAIT;
        end
        S_SSID_WAIT: begin
          res.ap_ssid[7:0] <= ssid_rd;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || pop) begin
            res   <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/classifier_checker.sv
// Checker for the frame classifier device table: predicts every result beat
// from the accepted input beats and compares it with the block's output.
// Depends on wfcdt_pkg for the result layout and code constants.
module classifier_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         func,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic [1:0]         pkt_kind,
  input  logic signed [7:0]  rx_rssi,
  input  logic [3:0]         rx_channel,
  input  logic [11:0]        frame_len,
  input  logic [31:0]        time_ms,
  input  logic [5:0]         select_index,
  input  logic [4:0]         ssid_pos,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         result_kind,
  input  logic               is_beacon,
  input  logic               is_deauth,
  input  logic               eapol_hit,
  input  logic [1:0]         dev_status,
  input  logic [5:0]         dev_index,
  input  logic [47:0]        mac_out,
  input  logic signed [7:0]  rssi_out,
  input  logic [3:0]         chan_out,
  input  logic [31:0]        count_out,
  input  logic [31:0]        seen_out,
  input  logic [8:0]         ap_ssid_byte,
  output int                 errors,
  output int                 pending
);
  import wfcdt_pkg::*;

  localparam int DEVS = DEF_MAX_DEVICES;
  localparam int SSIDB = DEF_SSID_BYTES;

  typedef enum int {TAG_SEEK, TAG_NUM, TAG_FOUND, TAG_DONE} tag_state_t;

  logic [47:0] tab_mac [DEVS];
  logic [7:0]  tab_rssi [DEVS];
  logic [3:0]  tab_chan [DEVS];
  logic [31:0] tab_frames [DEVS];
  logic [31:0] tab_seen [DEVS];
  logic        tab_ap [DEVS];
  logic [7:0]  tab_ssid [DEVS][SSIDB];
  int          tab_ssid_len [DEVS];
  int          dev_count;
  logic [31:0] stats [NUM_STATS];

  bit          frame_open;
  int          cur_len;
  logic [1:0]  cur_kind;
  int          offset;
  logic [7:0]  hdr [HDR_KEEP];
  int          tag_off;
  logic [7:0]  stage [SSIDB];
  int          stage_len;
  tag_state_t  tag_st;
  logic [7:0]  tag_id;

  res_t expected_results[$];
  int   mismatches;

  task automatic open_frame(input int len, input logic [1:0] kind);
    frame_open = 1;
    cur_len = len;
    cur_kind = kind;
    offset = 0;
    foreach (hdr[i]) hdr[i] = 8'h00;
    tag_off = TAG_START;
    foreach (stage[i]) stage[i] = 8'h00;
    stage_len = 0;
    tag_st = TAG_SEEK;
    tag_id = 8'h00;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int pos, tl, s;
    pos = offset;
    if (pos < cur_len) begin
      if (pos < HDR_KEEP) hdr[pos] = b;
      case (tag_st)
        TAG_SEEK: begin
          if (pos == tag_off) begin
            if (tag_off + 2 > cur_len) tag_st = TAG_DONE;
            else begin
              tag_id = b;
              tag_st = TAG_NUM;
            end
          end
        end
        TAG_NUM: begin
          tl = b;
          if (tag_off + 2 + tl > cur_len) tag_st = TAG_DONE;
          else if (tag_id == 8'h00) begin
            tag_st = TAG_FOUND;
            stage_len = (tl < SSIDB) ? tl : SSIDB;
          end else begin
            tag_off = tag_off + 2 + tl;
            tag_st = TAG_SEEK;
          end
        end
        TAG_FOUND: begin
          s = tag_off + 2;
          if (pos >= s && pos - s < stage_len)
            stage[pos - s] = (b >= 8'h20 && b <= 8'h7E) ? b : 8'h2E;
        end
        default: ;
      endcase
    end
    if (offset < 4095) offset++;
  endtask

  function automatic res_t entry_fields(input res_t r, input int i, input int sp);
    logic [7:0] sb;
    sb = (sp < tab_ssid_len[i]) ? tab_ssid[i][sp] : 8'h00;
    r.idx = i[5:0];
    r.mac = tab_mac[i];
    r.rssi = tab_rssi[i];
    r.chan = tab_chan[i];
    r.count = tab_frames[i];
    r.seen = tab_seen[i];
    r.ap_ssid = {tab_ap[i], sb};
    return r;
  endfunction

  task automatic close_frame(output res_t r);
    logic [1:0]  ftype;
    logic [3:0]  fsub;
    logic [47:0] mac;
    bit          bcn, dea, eap, hit;
    int          idx;
    r = '0;
    r.kind = RK_FRAME;
    frame_open = 0;
    stats[STAT_ALL]++;
    if (cur_kind == KIND_MGMT) stats[STAT_MGMT]++;
    else if (cur_kind == KIND_DATA) stats[STAT_DATA]++;
    else if (cur_kind == KIND_CTRL) stats[STAT_CTRL]++;
    if (cur_len < MIN_LEN) begin
      r.status = ST_SHORT;
      return;
    end
    ftype = hdr[0][3:2];
    fsub = hdr[0][7:4];
    bcn = ftype == 2'd0 && (fsub == SUB_BEACON || fsub == SUB_PROBE_RSP);
    dea = ftype == 2'd0 && (fsub == SUB_DEAUTH || fsub == SUB_DISASSOC);
    eap = 0;
    if (bcn) stats[STAT_BEACON]++;
    if (dea) stats[STAT_DEAUTH]++;
    if (cur_kind == KIND_DATA && cur_len >= EAPOL_MIN) begin
      if (hdr[24] == LLC_SNAP && hdr[25] == LLC_SNAP && hdr[26] == LLC_CTRL &&
          hdr[30] == ETH_EAPOL_HI && hdr[31] == ETH_EAPOL_LO)
        eap = 1;
      else if (hdr[0][3:0] == FC_QOS_DATA && hdr[26] == LLC_SNAP && hdr[27] == LLC_SNAP &&
               hdr[28] == LLC_CTRL && hdr[32] == ETH_EAPOL_HI && hdr[33] == ETH_EAPOL_LO)
        eap = 1;
    end
    if (eap) stats[STAT_EAPOL]++;
    r.beacon = bcn;
    r.deauth = dea;
    r.eapol = eap;
    mac = {hdr[10], hdr[11], hdr[12], hdr[13], hdr[14], hdr[15]};
    hit = 0;
    idx = 0;
    for (int i = 0; i < dev_count; i++) begin
      if (!hit && tab_mac[i] == mac) begin
        idx = i;
        hit = 1;
      end
    end
    if (hit) r.status = ST_EXIST;
    else if (dev_count >= DEVS) begin
      r.status = ST_FULL;
      r.mac = mac;
      return;
    end else begin
      idx = dev_count++;
      r.status = ST_NEW;
      tab_mac[idx] = mac;
      tab_frames[idx] = 0;
      tab_ap[idx] = 0;
      tab_ssid_len[idx] = 0;
      for (int k = 0; k < SSIDB; k++) tab_ssid[idx][k] = 8'h00;
    end
    tab_rssi[idx] = rx_rssi;
    tab_chan[idx] = rx_channel;
    tab_frames[idx]++;
    tab_seen[idx] = time_ms;
    if (bcn) begin
      tab_ap[idx] = 1;
      if (cur_len >= SSID_MIN_LEN) begin
        for (int k = 0; k < SSIDB; k++)
          tab_ssid[idx][k] = (tag_st == TAG_FOUND) ? stage[k] : 8'h00;
        tab_ssid_len[idx] = (tag_st == TAG_FOUND) ? stage_len : 0;
      end
    end
    r = entry_fields(r, idx, ssid_pos);
  endtask

  task automatic predict_beat();
    res_t r;
    r = '0;
    case (func_t'(func))
      FN_BYTE: begin
        if (first_byte) open_frame(frame_len, pkt_kind);
        if (frame_open) begin
          absorb_byte(data_byte);
          if (last_byte) begin
            close_frame(r);
            expected_results.push_back(r);
          end
        end
      end
      FN_READ: begin
        r.kind = RK_ENTRY;
        if (select_index < dev_count) r = entry_fields(r, select_index, ssid_pos);
        expected_results.push_back(r);
      end
      FN_CLEAR: begin
        dev_count = 0;
        foreach (stats[i]) stats[i] = '0;
        frame_open = 0;
      end
      default: begin
        r.kind = RK_STAT;
        if (select_index < NUM_STATS) r.count = stats[select_index];
        else if (select_index == STAT_DEVCNT) r.count = dev_count;
        expected_results.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t act, exp_r;
    if (rst) begin
      dev_count = 0;
      foreach (stats[i]) stats[i] = '0;
      open_frame(0, KIND_MGMT);
      frame_open = 0;
      expected_results.delete();
    end else begin
      if (pop && !empty) begin
        act = '{kind: result_kind, beacon: is_beacon, deauth: is_deauth, eapol: eapol_hit,
                status: dev_status, idx: dev_index, mac: mac_out, rssi: rssi_out,
                chan: chan_out, count: count_out, seen: seen_out, ap_ssid: ap_ssid_byte};
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result beat: %p", act);
        end else begin
          exp_r = expected_results.pop_front();
          if (act !== exp_r) begin
            errors++;
            if (mismatches++ < 10)
              $display("result mismatch\n  expected %p\n  actual   %p", exp_r, act);
          end
        end
      end
      if (push && !full) predict_beat();
    end
    pending = expected_results.size();
  end
endmodule

// File: verif/tb_top.sv
// Top of the frame classifier testbench: clock, reset, stimulus and verdict.
// Depends on wfcdt_pkg, the classifier_checker module and the block itself.
module tb_top;
  import wfcdt_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               push = 0;
  logic               full;
  logic [1:0]         func = FN_BYTE;
  logic [7:0]         data_byte = 0;
  logic               first_byte = 0;
  logic               last_byte = 0;
  logic [1:0]         pkt_kind = 0;
  logic signed [7:0]  rx_rssi = 0;
  logic [3:0]         rx_channel = 0;
  logic [11:0]        frame_len = 0;
  logic [31:0]        time_ms = 0;
  logic [5:0]         select_index = 0;
  logic [4:0]         ssid_pos = 0;
  logic               empty;
  logic               pop = 0;
  logic [1:0]         result_kind;
  logic               is_beacon, is_deauth, eapol_hit;
  logic [1:0]         dev_status;
  logic [5:0]         dev_index;
  logic [47:0]        mac_out;
  logic signed [7:0]  rssi_out;
  logic [3:0]         chan_out;
  logic [31:0]        count_out, seen_out;
  logic [8:0]         ap_ssid_byte;
  int                 errors, pending;

  int         beats_sent = 0;
  int         burst_left = 0;
  logic [47:0] mac_pool [8];
  logic [7:0]  frame_buf[$];

  always #5 clk = ~clk;

  wifi_frame_classifier_device_table_unit u_dut (.*);
  classifier_checker u_chk (.*);

  always @(posedge clk) begin
    int mode;
    mode = (beats_sent / 97) % 4;
    case (mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 1);
      2: pop <= ($urandom_range(0, 7) == 0);
      default: pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_beat(input func_t f, input logic [7:0] b, input logic fb,
                           input logic lb, input logic [1:0] kind, input logic [11:0] len,
                           input logic [5:0] sel);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
    end
    push <= 1'b1;
    func <= f;
    data_byte <= b;
    first_byte <= fb;
    last_byte <= lb;
    pkt_kind <= kind;
    frame_len <= len;
    rx_rssi <= 8'($urandom);
    rx_channel <= 4'($urandom);
    time_ms <= $urandom;
    select_index <= sel;
    ssid_pos <= 5'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom);
    do @(posedge clk); while (full);
    burst_left--;
    beats_sent++;
  endtask

  // Fills frame_buf with a frame of the given style; MACs come from a small pool
  // so that entries are hit again, or are fresh to grow the table.
  task automatic build_frame(input int style, input bit fresh_mac, output logic [1:0] kind);
    logic [47:0] mac;
    int n, tl;
    frame_buf.delete();
    n = (style == 4) ? 16 : $urandom_range(36, 44);
    repeat (n) frame_buf.push_back(8'($urandom));
    mac = fresh_mac ? 48'({$urandom, $urandom}) : mac_pool[$urandom_range(0, 7)];
    for (int i = 0; i < 6; i++) frame_buf[10 + i] = mac[47 - 8*i -: 8];
    kind = KIND_MGMT;
    case (style)
      0: begin
        frame_buf[0] = ($urandom_range(0, 1) == 1) ? 8'h80 : 8'h50;
        frame_buf = frame_buf[0:35];
        if ($urandom_range(0, 1) == 1) begin
          tl = $urandom_range(0, 4);
          frame_buf.push_back(8'($urandom_range(1, 255)));
          frame_buf.push_back(8'(tl));
          repeat (tl) frame_buf.push_back(8'($urandom));
        end
        tl = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 40) : $urandom_range(0, 12);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'(tl));
        repeat (tl) frame_buf.push_back(8'(($urandom_range(0, 4) == 0) ? $urandom
                                                                      : $urandom_range(32, 126)));
        repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
      end
      1: frame_buf[0] = ($urandom_range(0, 1) == 1) ? 8'hC0 : 8'hA0;
      2, 3: begin
        kind = KIND_DATA;
        frame_buf[0] = (style == 3) ? 8'h88 : 8'h08;
        tl = (style == 3) ? 26 : 24;
        if ($urandom_range(0, 3) != 0) begin
          frame_buf[tl] = LLC_SNAP;
          frame_buf[tl + 1] = LLC_SNAP;
          frame_buf[tl + 2] = LLC_CTRL;
          frame_buf[tl + 6] = ETH_EAPOL_HI;
          frame_buf[tl + 7] = ETH_EAPOL_LO;
        end
      end
      default: kind = 2'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) kind = 2'($urandom);
  endtask

  // Sends frame_buf; the declared length may exceed or fall short of what is sent.
  task automatic send_frame(input logic [1:0] kind, input int how);
    int n, len;
    n = frame_buf.size();
    len = n;
    if (how == 1) n = $urandom_range(1, n);
    else if (how == 2) len = $urandom_range(0, n);
    else if (how == 3) len = $urandom_range(n, 4095);
    for (int i = 0; i < n; i++)
      send_beat(FN_BYTE, frame_buf[i], i == 0, i == n - 1, kind,
                (i == 0) ? len[11:0] : 12'($urandom), 6'($urandom));
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0] k;
    int r;
    foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(FN_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int s = 0; s < 9; s++) send_beat(FN_STAT, 0, 0, 0, 0, 0, 6'(s));
    send_beat(FN_STAT, 0, 0, 0, 0, 0, 6'd63);
    send_beat(FN_READ, 0, 0, 0, 0, 0, 0);
    send_beat(FN_BYTE, 8'hFF, 0, 1, 0, 12'hFFF, 0);
    for (int s = 0; s < 5; s++) begin
      build_frame(s, 0, k);
      send_frame(k, 0);
    end
    build_frame(0, 0, k);
    send_beat(FN_BYTE, 8'h80, 1, 0, KIND_MGMT, 12'd40, 0);
    send_frame(k, 1);
    send_beat(FN_READ, 0, 0, 0, 0, 0, 0);
    for (int s = 0; s < 8; s++) send_beat(FN_STAT, 0, 0, 0, 0, 0, 6'(s));
    drain();
    send_beat(FN_READ, 0, 0, 0, 0, 0, 6'd63);
    send_beat(FN_CLEAR, 0, 0, 0, 0, 0, 0);

    while (beats_sent < 800) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        build_frame($urandom_range(0, 4), $urandom_range(0, 9) == 0, k);
        send_frame(k, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (r < 15) begin
        send_beat(FN_READ, 0, 0, 0, 0, 0,
                  6'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 9)));
      end else if (r < 17) begin
        send_beat(FN_STAT, 0, 0, 0, 0, 0,
                  6'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8)));
      end else if (r < 19) begin
        send_beat(FN_BYTE, 8'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
                  12'($urandom), 6'($urandom));
      end else if ($urandom_range(0, 5) == 0) begin
        send_beat(FN_CLEAR, 0, 0, 0, 0, 0, 0);
      end
      if (beats_sent > 500 && beats_sent < 560) drain();
    end

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #10000000;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
